// ===== design/lmae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmae_pkg
// shared constants and types for the link-discovery management-address
// extractor
// ----------------------------------------------------------------------------
package lmae_pkg;

  localparam int MAX_FRAME = 1536;
  localparam int OFFSET_W  = $clog2(MAX_FRAME + 1);

  localparam int HEADER_BYTES = 14;
  localparam int KIND_W       = 7;
  localparam int LEN_W        = 9;
  localparam int ADDR_W       = 32;

  localparam logic [KIND_W-1:0] KIND_END     = 7'd0;
  localparam logic [KIND_W-1:0] KIND_MGMT    = 7'd8;
  localparam logic [7:0]        MGMT_STRLEN  = 8'd5;
  localparam logic [7:0]        MGMT_IPV4    = 8'd1;
  localparam logic [LEN_W-1:0]  MGMT_MIN_LEN = 9'd6;
  localparam logic [LEN_W-1:0]  ADDR_LAST_POS = 9'd5;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_HDR_HI,
    PH_HDR_LO,
    PH_VALUE,
    PH_DONE
  } phase_t;

endpackage

// ===== design/lldp_mgmt_address_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lldp_mgmt_address_extractor_unit
// Takes received link-discovery frames one byte per cycle, skips the 14-byte
// header, walks the TLVs and picks up the first complete management-address
// TLV that carries an IPv4 address (string length 5, subtype 1, length at
// least 6). On the last byte of every frame one result transaction comes out
// with the known flag, the stored neighbor address and whether this frame
// changed it. A byte is taken every cycle but for the stall below: the parse
// state updates in the cycle the byte is accepted and the result lands in an
// output register in the next cycle. Bytes that end no frame are accepted
// even while a result is stalled; a frame's last byte waits only while the
// output register is full and not being taken. Bytes at frame positions of
// 1536 and above are ignored except for ending the frame.
// ----------------------------------------------------------------------------
module lldp_mgmt_address_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_addr_known,
  output logic [31:0] out_neighbor_addr,
  output logic        out_addr_changed
);

  logic [lmae_pkg::OFFSET_W-1:0] byte_offset_r, byte_offset_nxt;
  lmae_pkg::phase_t              parse_phase_r, parse_phase_nxt;
  logic [7:0]                    header_high_r, header_high_nxt;
  logic [lmae_pkg::KIND_W-1:0]   tlv_kind_r, tlv_kind_nxt;
  logic [lmae_pkg::LEN_W-1:0]    tlv_length_r, tlv_length_nxt;
  logic [lmae_pkg::LEN_W-1:0]    value_position_r, value_position_nxt;
  logic                          candidate_ok_r, candidate_ok_nxt;
  logic [lmae_pkg::ADDR_W-1:0]   candidate_addr_r, candidate_addr_nxt;
  logic                          frame_changed_r, frame_changed_nxt;
  logic [lmae_pkg::ADDR_W-1:0]   stored_addr_r, stored_addr_nxt;
  logic                          stored_known_r, stored_known_nxt;

  logic                          out_valid_r;
  logic                          out_addr_known_r;
  logic [31:0]                   out_neighbor_addr_r;
  logic                          out_addr_changed_r;

  logic                          in_accept;

  assign in_ready  = out_ready || !out_valid_r || !in_frame_last;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    logic [lmae_pkg::LEN_W-1:0] pos_inc;
    logic                       cand_ok;
    byte_offset_nxt    = byte_offset_r;
    parse_phase_nxt    = parse_phase_r;
    header_high_nxt    = header_high_r;
    tlv_kind_nxt       = tlv_kind_r;
    tlv_length_nxt     = tlv_length_r;
    value_position_nxt = value_position_r;
    candidate_ok_nxt   = candidate_ok_r;
    candidate_addr_nxt = candidate_addr_r;
    frame_changed_nxt  = frame_changed_r;
    stored_addr_nxt    = stored_addr_r;
    stored_known_nxt   = stored_known_r;
    pos_inc            = value_position_r + lmae_pkg::LEN_W'(1);
    cand_ok            = candidate_ok_r;

    if (in_accept && (byte_offset_r < lmae_pkg::OFFSET_W'(lmae_pkg::MAX_FRAME))) begin
      byte_offset_nxt = byte_offset_r + lmae_pkg::OFFSET_W'(1);
      case (parse_phase_r)
        lmae_pkg::PH_SKIP: begin
          if (byte_offset_r >= lmae_pkg::OFFSET_W'(lmae_pkg::HEADER_BYTES - 1)) begin
            parse_phase_nxt = lmae_pkg::PH_HDR_HI;
          end
        end
        lmae_pkg::PH_HDR_HI: begin
          header_high_nxt = in_rx_byte;
          parse_phase_nxt = lmae_pkg::PH_HDR_LO;
        end
        lmae_pkg::PH_HDR_LO: begin
          tlv_kind_nxt       = header_high_r[7:1];
          tlv_length_nxt     = {header_high_r[0], in_rx_byte};
          value_position_nxt = '0;
          candidate_ok_nxt   = 1'b0;
          candidate_addr_nxt = '0;
          if (header_high_r[7:1] == lmae_pkg::KIND_END) begin
            parse_phase_nxt = lmae_pkg::PH_DONE;
          end else if ({header_high_r[0], in_rx_byte} == '0) begin
            parse_phase_nxt = lmae_pkg::PH_HDR_HI;
          end else begin
            parse_phase_nxt = lmae_pkg::PH_VALUE;
          end
        end
        lmae_pkg::PH_VALUE: begin
          if (tlv_kind_r == lmae_pkg::KIND_MGMT) begin
            if (value_position_r == '0) begin
              cand_ok = (in_rx_byte == lmae_pkg::MGMT_STRLEN) &&
                        (tlv_length_r >= lmae_pkg::MGMT_MIN_LEN);
            end else if (value_position_r == lmae_pkg::LEN_W'(1)) begin
              cand_ok = candidate_ok_r && (in_rx_byte == lmae_pkg::MGMT_IPV4);
            end else if (value_position_r <= lmae_pkg::ADDR_LAST_POS) begin
              candidate_addr_nxt = {candidate_addr_r[lmae_pkg::ADDR_W-9:0], in_rx_byte};
            end
          end
          candidate_ok_nxt   = cand_ok;
          value_position_nxt = pos_inc;
          if (pos_inc == tlv_length_r) begin
            if ((tlv_kind_r == lmae_pkg::KIND_MGMT) && cand_ok) begin
              if (!stored_known_r || (stored_addr_r != candidate_addr_nxt)) begin
                stored_addr_nxt   = candidate_addr_nxt;
                stored_known_nxt  = 1'b1;
                frame_changed_nxt = 1'b1;
              end
              parse_phase_nxt = lmae_pkg::PH_DONE;
            end else begin
              parse_phase_nxt = lmae_pkg::PH_HDR_HI;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // parse state, cleared at every frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r    <= '0;
      parse_phase_r    <= lmae_pkg::PH_SKIP;
      header_high_r    <= '0;
      tlv_kind_r       <= '0;
      tlv_length_r     <= '0;
      value_position_r <= '0;
      candidate_ok_r   <= 1'b0;
      candidate_addr_r <= '0;
      frame_changed_r  <= 1'b0;
      stored_addr_r    <= '0;
      stored_known_r   <= 1'b0;
    end else begin
      stored_addr_r  <= stored_addr_nxt;
      stored_known_r <= stored_known_nxt;
      if (in_accept && in_frame_last) begin
        byte_offset_r    <= '0;
        parse_phase_r    <= lmae_pkg::PH_SKIP;
        header_high_r    <= '0;
        tlv_kind_r       <= '0;
        tlv_length_r     <= '0;
        value_position_r <= '0;
        candidate_ok_r   <= 1'b0;
        candidate_addr_r <= '0;
        frame_changed_r  <= 1'b0;
      end else begin
        byte_offset_r    <= byte_offset_nxt;
        parse_phase_r    <= parse_phase_nxt;
        header_high_r    <= header_high_nxt;
        tlv_kind_r       <= tlv_kind_nxt;
        tlv_length_r     <= tlv_length_nxt;
        value_position_r <= value_position_nxt;
        candidate_ok_r   <= candidate_ok_nxt;
        candidate_addr_r <= candidate_addr_nxt;
        frame_changed_r  <= frame_changed_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_frame_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_frame_last) begin
      out_addr_known_r    <= stored_known_nxt;
      out_neighbor_addr_r <= stored_known_nxt ? stored_addr_nxt : '0;
      out_addr_changed_r  <= frame_changed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_addr_known    = out_addr_known_r;
  assign out_neighbor_addr = out_neighbor_addr_r;
  assign out_addr_changed  = out_addr_changed_r;

endmodule
